### rtl/pmi_pkg.sv
// shared types, constants and fixed-point helpers for the point mass integrator
// no dependencies; used by pmi_ctrl, pmi_dp and point_mass_integrator
package pmi_pkg;

    localparam int QW         = 32;   // Q16.16 word
    localparam int DT_W       = 17;
    localparam int DT2_W      = 18;   // rounded square of the largest time step
    localparam int INV_W      = 32;
    localparam int DAMP_W     = 17;
    localparam int MODE_W     = 2;
    localparam int REQ_W      = 2;
    localparam int OPND_W     = 33;   // multiplier operand, signed
    localparam int PROD_W     = 64;
    localparam int WIDE_W     = 66;
    localparam int AXES       = 3;
    localparam int AXIS_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int VEC_W      = AXES * QW;
    localparam int IN_DATA_W  = 3 * VEC_W;
    localparam int OUT_DATA_W = 3 * VEC_W;

    localparam logic [AXIS_W-1:0] AXIS_FIRST = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_LAST  = 2'd2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_INV_MASS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA_T    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DAMP_EN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DAMP_STEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FROZEN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_PERS = 3'd6;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_LOAD      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STEP_NEW  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STEP_HELD = 2'd2;

    // integrator modes, the unused code runs velocity verlet
    localparam logic [MODE_W-1:0] MODE_EULER  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VERLET = 2'd1;
    localparam logic [MODE_W-1:0] MODE_VEL_VERLET = 2'd2;

    localparam logic [INV_W-1:0]  RST_INV_MASS  = 32'd65536;
    localparam logic [DT_W-1:0]   RST_DELTA_T   = 17'd1092;
    localparam logic [DAMP_W-1:0] RST_DAMP_STEP = 17'd65536;

    typedef struct packed {
        logic [INV_W-1:0]  inv_mass;
        logic [DT_W-1:0]   delta_t;
        logic [MODE_W-1:0] integrator_mode;
        logic              damp_enable;
        logic [DAMP_W-1:0] damp_per_step;
        logic              frozen;
        logic              force_persistent;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DT2_M,   ST_DT2_W,
        ST_ACC_M,   ST_ACC_W,
        ST_EPOS_M,  ST_EPOS_W,
        ST_EVEL_M,  ST_EVEL_W,
        ST_DAMP_M,  ST_DAMP_W,
        ST_VPOS_M,  ST_VPOS_W,
        ST_VVH_M,   ST_VVH_W,
        ST_VVPOS_M, ST_VVPOS_W,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_MUL_DT2,
        DP_MUL_ACC,
        DP_MUL_VDT,
        DP_MUL_ADT,
        DP_MUL_DAMP,
        DP_MUL_ADT2,
        DP_WB_DT2,
        DP_WB_ACC,
        DP_WB_EPOS,
        DP_WB_EVEL,
        DP_WB_DAMP,
        DP_WB_VPOS,
        DP_WB_VVH,
        DP_WB_VVPOS
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [AXIS_W-1:0] axis;
        logic              latch_force;
        logic              load_state;
        logic              capture;
        logic              clear_force;
    } cmd_t;

    function automatic logic signed [WIDE_W-1:0] sx_wide(input logic signed [QW-1:0] x);
        return {{(WIDE_W-QW){x[QW-1]}}, x};
    endfunction

    // round half up, then arithmetic shift
    function automatic logic signed [WIDE_W-1:0] rnd16(input logic signed [PROD_W-1:0] v);
        logic signed [WIDE_W-1:0] t;
        t = {{(WIDE_W-PROD_W){v[PROD_W-1]}}, v} + (WIDE_W'(1) <<< 15);
        return t >>> 16;
    endfunction

    function automatic logic signed [WIDE_W-1:0] rnd17(input logic signed [PROD_W-1:0] v);
        logic signed [WIDE_W-1:0] t;
        t = {{(WIDE_W-PROD_W){v[PROD_W-1]}}, v} + (WIDE_W'(1) <<< 16);
        return t >>> 17;
    endfunction

    function automatic logic signed [QW-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [QW-1:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/pmi_ctrl.sv
// sequencer for the point mass integrator: walks the multiply and writeback steps per axis
// and owns the input ready and result valid handshakes; uses pmi_pkg
module pmi_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  pmi_pkg::cfg_t              cfg,
    input  logic                       in_valid,
    input  logic [pmi_pkg::REQ_W-1:0]  in_req,
    output logic                       in_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    output pmi_pkg::cmd_t              cmd
);

    pmi_pkg::state_t                 state_reg, state_next;
    logic [pmi_pkg::AXIS_W-1:0]      axis_reg, axis_next;
    logic                            step_reg, step_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            in_fire;
    logic                            is_step;
    logic                            take;

    assign in_ready  = (state_reg == pmi_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign is_step   = (in_req == pmi_pkg::REQ_STEP_NEW) || (in_req == pmi_pkg::REQ_STEP_HELD);
    // result register is free or drains this cycle
    assign take      = (state_reg == pmi_pkg::ST_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pmi_pkg::ST_IDLE;
            axis_reg      <= pmi_pkg::AXIS_FIRST;
            step_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (take) begin
            out_valid_next = 1'b1;
        end
        case (state_reg)
            pmi_pkg::ST_IDLE: begin
                if (in_fire) begin
                    axis_next = pmi_pkg::AXIS_FIRST;
                    step_next = is_step;
                    if (is_step && !cfg.frozen) begin
                        if (cfg.integrator_mode == pmi_pkg::MODE_VERLET) begin
                            state_next = pmi_pkg::ST_DT2_M;
                        end else begin
                            state_next = pmi_pkg::ST_ACC_M;
                        end
                    end else begin
                        state_next = pmi_pkg::ST_DONE;
                    end
                end
            end
            pmi_pkg::ST_DT2_M:  state_next = pmi_pkg::ST_DT2_W;
            pmi_pkg::ST_DT2_W:  state_next = pmi_pkg::ST_ACC_M;
            pmi_pkg::ST_ACC_M:  state_next = pmi_pkg::ST_ACC_W;
            pmi_pkg::ST_ACC_W: begin
                if (cfg.integrator_mode == pmi_pkg::MODE_EULER) begin
                    state_next = pmi_pkg::ST_EPOS_M;
                end else if (cfg.integrator_mode == pmi_pkg::MODE_VERLET) begin
                    state_next = pmi_pkg::ST_VPOS_M;
                end else begin
                    state_next = pmi_pkg::ST_VVH_M;
                end
            end
            pmi_pkg::ST_EPOS_M:  state_next = pmi_pkg::ST_EPOS_W;
            pmi_pkg::ST_EPOS_W:  state_next = pmi_pkg::ST_EVEL_M;
            pmi_pkg::ST_EVEL_M:  state_next = pmi_pkg::ST_EVEL_W;
            pmi_pkg::ST_DAMP_M:  state_next = pmi_pkg::ST_DAMP_W;
            pmi_pkg::ST_VPOS_M:  state_next = pmi_pkg::ST_VPOS_W;
            pmi_pkg::ST_VVH_M:   state_next = pmi_pkg::ST_VVH_W;
            pmi_pkg::ST_VVH_W:   state_next = pmi_pkg::ST_VVPOS_M;
            pmi_pkg::ST_VVPOS_M: state_next = pmi_pkg::ST_VVPOS_W;
            pmi_pkg::ST_EVEL_W,
            pmi_pkg::ST_DAMP_W,
            pmi_pkg::ST_VPOS_W,
            pmi_pkg::ST_VVPOS_W: begin
                if ((state_reg == pmi_pkg::ST_EVEL_W) && cfg.damp_enable) begin
                    state_next = pmi_pkg::ST_DAMP_M;
                end else if (axis_reg == pmi_pkg::AXIS_LAST) begin
                    state_next = pmi_pkg::ST_DONE;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = pmi_pkg::ST_ACC_M;
                end
            end
            pmi_pkg::ST_DONE: begin
                if (take) begin
                    state_next = pmi_pkg::ST_IDLE;
                end
            end
            default: state_next = pmi_pkg::ST_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        cmd             = '0;
        cmd.op          = pmi_pkg::DP_NOP;
        cmd.axis        = axis_reg;
        case (state_reg)
            pmi_pkg::ST_IDLE: begin
                cmd.latch_force = in_fire && ((in_req == pmi_pkg::REQ_LOAD) ||
                                              (in_req == pmi_pkg::REQ_STEP_NEW));
                cmd.load_state  = in_fire && (in_req == pmi_pkg::REQ_LOAD);
            end
            pmi_pkg::ST_DT2_M:   cmd.op = pmi_pkg::DP_MUL_DT2;
            pmi_pkg::ST_DT2_W:   cmd.op = pmi_pkg::DP_WB_DT2;
            pmi_pkg::ST_ACC_M:   cmd.op = pmi_pkg::DP_MUL_ACC;
            pmi_pkg::ST_ACC_W:   cmd.op = pmi_pkg::DP_WB_ACC;
            pmi_pkg::ST_EPOS_M:  cmd.op = pmi_pkg::DP_MUL_VDT;
            pmi_pkg::ST_EPOS_W:  cmd.op = pmi_pkg::DP_WB_EPOS;
            pmi_pkg::ST_EVEL_M:  cmd.op = pmi_pkg::DP_MUL_ADT;
            pmi_pkg::ST_EVEL_W:  cmd.op = pmi_pkg::DP_WB_EVEL;
            pmi_pkg::ST_DAMP_M:  cmd.op = pmi_pkg::DP_MUL_DAMP;
            pmi_pkg::ST_DAMP_W:  cmd.op = pmi_pkg::DP_WB_DAMP;
            pmi_pkg::ST_VPOS_M:  cmd.op = pmi_pkg::DP_MUL_ADT2;
            pmi_pkg::ST_VPOS_W:  cmd.op = pmi_pkg::DP_WB_VPOS;
            pmi_pkg::ST_VVH_M:   cmd.op = pmi_pkg::DP_MUL_ADT;
            pmi_pkg::ST_VVH_W:   cmd.op = pmi_pkg::DP_WB_VVH;
            pmi_pkg::ST_VVPOS_M: cmd.op = pmi_pkg::DP_MUL_VDT;
            pmi_pkg::ST_VVPOS_W: cmd.op = pmi_pkg::DP_WB_VVPOS;
            pmi_pkg::ST_DONE: begin
                cmd.capture     = take;
                cmd.clear_force = take && step_reg && !cfg.force_persistent;
            end
            default: cmd.op = pmi_pkg::DP_NOP;
        endcase
    end

    a_accept_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg != pmi_pkg::ST_IDLE))
        else $error("accepted word did not start work");

    a_axis_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != pmi_pkg::ST_IDLE) |-> (axis_reg != 2'd3))
        else $error("axis counter out of range");

    a_capture_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> out_valid_reg)
        else $error("captured result not presented");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> !(out_valid_reg && !out_ready))
        else $error("result register overwritten while held");

endmodule

### rtl/pmi_dp.sv
// datapath of the point mass integrator: state registers, one shared multiplier,
// rounding, saturation and the result register; uses pmi_pkg
module pmi_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  pmi_pkg::cfg_t                   cfg,
    input  pmi_pkg::cmd_t                   cmd,
    input  logic [pmi_pkg::IN_DATA_W-1:0]   in_data,
    output logic [pmi_pkg::OUT_DATA_W-1:0]  out_data
);

    localparam int QW = pmi_pkg::QW;

    logic signed [QW-1:0] pos_reg   [pmi_pkg::AXES];
    logic signed [QW-1:0] pos_next  [pmi_pkg::AXES];
    logic signed [QW-1:0] prev_reg  [pmi_pkg::AXES];
    logic signed [QW-1:0] prev_next [pmi_pkg::AXES];
    logic signed [QW-1:0] vel_reg   [pmi_pkg::AXES];
    logic signed [QW-1:0] vel_next  [pmi_pkg::AXES];
    logic signed [QW-1:0] acc_reg   [pmi_pkg::AXES];
    logic signed [QW-1:0] acc_next  [pmi_pkg::AXES];
    logic signed [QW-1:0] frc_reg   [pmi_pkg::AXES];
    logic signed [QW-1:0] frc_next  [pmi_pkg::AXES];

    logic signed [pmi_pkg::PROD_W-1:0] prod_reg;
    logic [pmi_pkg::DT2_W-1:0]         dt2_reg;
    logic signed [QW-1:0]              h_reg;
    logic [pmi_pkg::OUT_DATA_W-1:0]    out_reg;

    logic signed [pmi_pkg::OPND_W-1:0] mul_a, mul_b;
    logic signed [pmi_pkg::WIDE_W-1:0] prod_full;
    logic                              is_mul;
    logic signed [pmi_pkg::WIDE_W-1:0] r16;
    logic signed [QW-1:0]              r16s, r17s;
    logic signed [QW-1:0]              pos_i, prev_i, vel_i, acc_i, frc_i;

    assign pos_i  = pos_reg[cmd.axis];
    assign prev_i = prev_reg[cmd.axis];
    assign vel_i  = vel_reg[cmd.axis];
    assign acc_i  = acc_reg[cmd.axis];
    assign frc_i  = frc_reg[cmd.axis];

    // operand select for the shared multiplier
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        is_mul = 1'b1;
        case (cmd.op)
            pmi_pkg::DP_MUL_DT2: begin
                mul_a = {16'b0, cfg.delta_t};
                mul_b = {16'b0, cfg.delta_t};
            end
            pmi_pkg::DP_MUL_ACC: begin
                mul_a = {frc_i[QW-1], frc_i};
                mul_b = {1'b0, cfg.inv_mass};
            end
            pmi_pkg::DP_MUL_VDT: begin
                mul_a = {vel_i[QW-1], vel_i};
                mul_b = {16'b0, cfg.delta_t};
            end
            pmi_pkg::DP_MUL_ADT: begin
                mul_a = {acc_i[QW-1], acc_i};
                mul_b = {16'b0, cfg.delta_t};
            end
            pmi_pkg::DP_MUL_DAMP: begin
                mul_a = {vel_i[QW-1], vel_i};
                mul_b = {16'b0, cfg.damp_per_step};
            end
            pmi_pkg::DP_MUL_ADT2: begin
                mul_a = {acc_i[QW-1], acc_i};
                mul_b = {15'b0, dt2_reg};
            end
            default: is_mul = 1'b0;
        endcase
    end

    assign prod_full = mul_a * mul_b;
    assign r16       = pmi_pkg::rnd16(prod_reg);
    assign r16s      = pmi_pkg::sat32(r16);
    assign r17s      = pmi_pkg::sat32(pmi_pkg::rnd17(prod_reg));

    // writeback and load
    always_comb begin
        pos_next  = pos_reg;
        prev_next = prev_reg;
        vel_next  = vel_reg;
        acc_next  = acc_reg;
        frc_next  = frc_reg;
        case (cmd.op)
            pmi_pkg::DP_WB_ACC: begin
                acc_next[cmd.axis] = r16s;
            end
            pmi_pkg::DP_WB_EPOS: begin
                pos_next[cmd.axis] = pmi_pkg::sat32(pmi_pkg::sx_wide(pos_i) +
                                                    pmi_pkg::sx_wide(r16s));
            end
            pmi_pkg::DP_WB_EVEL: begin
                vel_next[cmd.axis] = pmi_pkg::sat32(pmi_pkg::sx_wide(vel_i) +
                                                    pmi_pkg::sx_wide(r16s));
            end
            pmi_pkg::DP_WB_DAMP: begin
                vel_next[cmd.axis] = r16s;
            end
            pmi_pkg::DP_WB_VPOS: begin
                // 2x - prev + a*dt^2, kept wide until the final clamp
                pos_next[cmd.axis]  = pmi_pkg::sat32((pmi_pkg::sx_wide(pos_i) <<< 1) -
                                                     pmi_pkg::sx_wide(prev_i) + r16);
                prev_next[cmd.axis] = pos_i;
            end
            pmi_pkg::DP_WB_VVH: begin
                // velocity holds the half step until the position update
                vel_next[cmd.axis] = pmi_pkg::sat32(pmi_pkg::sx_wide(vel_i) +
                                                    pmi_pkg::sx_wide(r17s));
            end
            pmi_pkg::DP_WB_VVPOS: begin
                pos_next[cmd.axis] = pmi_pkg::sat32(pmi_pkg::sx_wide(pos_i) +
                                                    pmi_pkg::sx_wide(r16s));
                vel_next[cmd.axis] = pmi_pkg::sat32(pmi_pkg::sx_wide(vel_i) +
                                                    pmi_pkg::sx_wide(h_reg));
            end
            default: begin
            end
        endcase
        for (int i = 0; i < pmi_pkg::AXES; i++) begin
            if (cmd.latch_force) begin
                frc_next[i] = in_data[i*QW +: QW];
            end
            if (cmd.clear_force) begin
                frc_next[i] = '0;
            end
            if (cmd.load_state) begin
                pos_next[i]  = in_data[pmi_pkg::VEC_W + i*QW +: QW];
                prev_next[i] = in_data[pmi_pkg::VEC_W + i*QW +: QW];
                vel_next[i]  = in_data[2*pmi_pkg::VEC_W + i*QW +: QW];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pmi_pkg::AXES; i++) begin
                pos_reg[i]  <= '0;
                prev_reg[i] <= '0;
                vel_reg[i]  <= '0;
                acc_reg[i]  <= '0;
                frc_reg[i]  <= '0;
            end
        end else begin
            pos_reg  <= pos_next;
            prev_reg <= prev_next;
            vel_reg  <= vel_next;
            acc_reg  <= acc_next;
            frc_reg  <= frc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (is_mul) begin
            prod_reg <= prod_full[pmi_pkg::PROD_W-1:0];
        end
        if (cmd.op == pmi_pkg::DP_WB_DT2) begin
            dt2_reg <= r16[pmi_pkg::DT2_W-1:0];
        end
        if (cmd.op == pmi_pkg::DP_WB_VVH) begin
            h_reg <= r17s;
        end
        if (cmd.capture) begin
            for (int i = 0; i < pmi_pkg::AXES; i++) begin
                out_reg[i*QW +: QW]                     <= pos_reg[i];
                out_reg[pmi_pkg::VEC_W + i*QW +: QW]    <= vel_reg[i];
                out_reg[2*pmi_pkg::VEC_W + i*QW +: QW]  <= acc_reg[i];
            end
        end
    end

    assign out_data = out_reg;

endmodule

### rtl/point_mass_integrator.sv
// point mass integrator top level: configuration registers, sequencer and datapath
// depends on pmi_pkg, pmi_ctrl and pmi_dp
// loads, frozen steps and unused requests go to the result register without arithmetic;
// a step in basic verlet, euler (plus damping if enabled) or velocity verlet runs on
// one shared 33x33 multiplier, each product registered, then written back, three axes
// one word in work at a time; the next word is taken once the result is captured
// reset (aresetn low, synchronous) zeroes the motion state and loads register defaults
module point_mass_integrator (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // force_x, force_y, force_z, load_pos_x/y/z, load_vel_x/y/z, 32 bits each
    input  logic [pmi_pkg::IN_DATA_W-1:0]     s_tdata,
    // req_type
    input  logic [pmi_pkg::REQ_W-1:0]         s_tuser,
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pos_x/y/z, vel_x/y/z, acc_x/y/z, 32 bits each
    output logic [pmi_pkg::OUT_DATA_W-1:0]    m_tdata,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pmi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pmi_pkg::CFG_DATA_W-1:0]    cfg_data
);

    pmi_pkg::cfg_t cfg_reg, cfg_next;
    pmi_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                pmi_pkg::REG_INV_MASS:   cfg_next.inv_mass         = cfg_data[pmi_pkg::INV_W-1:0];
                pmi_pkg::REG_DELTA_T:    cfg_next.delta_t          = cfg_data[pmi_pkg::DT_W-1:0];
                pmi_pkg::REG_MODE:       cfg_next.integrator_mode  = cfg_data[pmi_pkg::MODE_W-1:0];
                pmi_pkg::REG_DAMP_EN:    cfg_next.damp_enable      = cfg_data[0];
                pmi_pkg::REG_DAMP_STEP:  cfg_next.damp_per_step    = cfg_data[pmi_pkg::DAMP_W-1:0];
                pmi_pkg::REG_FROZEN:     cfg_next.frozen           = cfg_data[0];
                pmi_pkg::REG_FORCE_PERS: cfg_next.force_persistent = cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inv_mass         <= pmi_pkg::RST_INV_MASS;
            cfg_reg.delta_t          <= pmi_pkg::RST_DELTA_T;
            cfg_reg.integrator_mode  <= pmi_pkg::MODE_EULER;
            cfg_reg.damp_enable      <= 1'b0;
            cfg_reg.damp_per_step    <= pmi_pkg::RST_DAMP_STEP;
            cfg_reg.frozen           <= 1'b0;
            cfg_reg.force_persistent <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pmi_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_req    (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    pmi_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .out_data (m_tdata)
    );

endmodule
